/* rtl/skl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skl_pkg
// Shared types and constants for the sorted key list table.
// ---------------------------------------------------------------------------
package skl_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 16;
   localparam int          START_KEY_DEF   = 50;

   localparam int unsigned KEY_W     = 32;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned ACTION_W  = 3;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned COUNT_W   = 5;

   localparam logic signed [KEY_W-1:0] KEY_MIN  = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX  = {1'b0, {(KEY_W-1){1'b1}}};
   localparam logic signed [KEY_W-1:0] KEY_NONE = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PREPEND     = 3'd0,
      ACT_APPEND      = 3'd1,
      ACT_REMOVE_HEAD = 3'd2,
      ACT_INSERT      = 3'd3,
      ACT_REMOVE_KEY  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE      = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      action_type                 action;
      logic                       apply;
      logic signed [KEY_W-1:0]    new_key;
      logic [PAYLOAD_W-1:0]       new_payload;
      logic signed [KEY_W-1:0]    match_key;
   } cell_ctrl_type;

   // compare results from one cell
   typedef struct packed {
      logic below;
      logic ge;
      logic eq;
   } cell_flags_type;

endpackage

/* rtl/skl_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skl_cell
// One table slot: holds a key and payload, compares against the request
// key and shifts toward either neighbor or loads a new entry.
// ---------------------------------------------------------------------------
module skl_cell
   import skl_pkg::*;
(
   input  logic                        clock,
   input  cell_ctrl_type               ctrl,
   input  logic                        occupied,
   input  logic                        append_slot,
   input  logic                        left_before,
   input  logic signed [KEY_W-1:0]     left_key,
   input  logic [PAYLOAD_W-1:0]        left_payload,
   input  logic signed [KEY_W-1:0]     right_key,
   input  logic [PAYLOAD_W-1:0]        right_payload,
   output cell_flags_type              flags,
   output logic signed [KEY_W-1:0]     key,
   output logic [PAYLOAD_W-1:0]        payload
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;
   logic [PAYLOAD_W-1:0]    payload_ff;
   logic [PAYLOAD_W-1:0]    payload_in;
   logic                    less;

   always_comb begin
      less        = key_ff < ctrl.match_key;
      flags.below = occupied && less;
      flags.ge    = occupied && !less;
      flags.eq    = occupied && (key_ff == ctrl.match_key);
   end

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.apply) begin
         case (ctrl.action)
            ACT_PREPEND: begin
               key_in     = left_key;
               payload_in = left_payload;
            end
            ACT_APPEND: begin
               if (append_slot) begin
                  key_in     = ctrl.new_key;
                  payload_in = ctrl.new_payload;
               end
            end
            ACT_REMOVE_HEAD: begin
               key_in     = right_key;
               payload_in = right_payload;
            end
            ACT_INSERT: begin
               if (!flags.below) begin
                  if (left_before) begin
                     key_in     = ctrl.new_key;
                     payload_in = ctrl.new_payload;
                  end else begin
                     key_in     = left_key;
                     payload_in = left_payload;
                  end
               end
            end
            ACT_REMOVE_KEY: begin
               if (flags.ge) begin
                  key_in     = right_key;
                  payload_in = right_payload;
               end
            end
            default: begin
               key_in     = key_ff;
               payload_in = payload_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

/* rtl/sorted_key_list_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_key_list_table
// The response to an accepted request is registered and appears in the cycle after it.
// Throughput: one request per cycle while the response side does not stall; every cell compares and shifts at once.
// Reset clears the entry count and the response valid; cell contents are
// left as they are and only occupied cells are ever read.
// ---------------------------------------------------------------------------
module sorted_key_list_table
   import skl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int          START_KEY   = START_KEY_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ACTION_W-1:0]         req_action,
   input  logic [PAYLOAD_W-1:0]        req_payload,
   input  logic signed [KEY_W-1:0]     req_sort_key,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [PAYLOAD_W-1:0]        rsp_out_payload,
   output logic signed [KEY_W-1:0]     rsp_out_key,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [COUNT_W-1:0]          rsp_entry_count
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic signed [KEY_W-1:0] START = KEY_W'(START_KEY);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [PAYLOAD_W-1:0]    out_payload_ff;
   logic [PAYLOAD_W-1:0]    out_payload_in;
   logic signed [KEY_W-1:0] out_key_ff;
   logic signed [KEY_W-1:0] out_key_in;
   status_type              status_ff;
   status_type              status_in;

   cell_ctrl_type           ctrl;
   action_type              action;
   logic                    fire;
   logic                    full;
   logic                    empty;
   logic                    found;
   logic signed [KEY_W-1:0] head_key;
   logic signed [KEY_W-1:0] tail_key;
   logic [PAYLOAD_W-1:0]    match_payload;

   logic signed [KEY_W-1:0] cell_key     [TABLE_DEPTH];
   logic [PAYLOAD_W-1:0]    cell_payload [TABLE_DEPTH];
   cell_flags_type          cell_flags   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  occupied;
   logic [TABLE_DEPTH-1:0]  tail_slot;
   logic [TABLE_DEPTH-1:0]  append_slot;
   logic [TABLE_DEPTH-1:0]  first_hit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;
   assign action    = action_type'(req_action);
   assign full      = count_ff == CNT_W'(TABLE_DEPTH);
   assign empty     = count_ff == '0;

   // per-slot position decode
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
      assign occupied[i]    = CNT_W'(i) < count_ff;
      assign tail_slot[i]   = CNT_W'(i + 1) == count_ff;
      assign append_slot[i] = CNT_W'(i) == count_ff;
      if (i == 0) begin : g_first
         assign first_hit[i] = cell_flags[i].ge && cell_flags[i].eq;
      end else begin : g_rest
         assign first_hit[i] = cell_flags[i].ge && cell_flags[i].eq
                               && cell_flags[i-1].below;
      end
   end

   always_comb begin
      head_key      = cell_key[0];
      tail_key      = '0;
      match_payload = '0;
      found         = 1'b0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         if (tail_slot[j]) begin
            tail_key = tail_key | cell_key[j];
         end
         if (first_hit[j]) begin
            match_payload = match_payload | cell_payload[j];
            found         = 1'b1;
         end
      end
   end

   always_comb begin
      ctrl.action      = action;
      ctrl.match_key   = req_sort_key;
      ctrl.new_payload = req_payload;
      ctrl.new_key     = req_sort_key;
      ctrl.apply       = 1'b0;
      case (action)
         ACT_PREPEND: begin
            ctrl.apply = fire && !full;
            if (empty) begin
               ctrl.new_key = START;
            end else if (head_key == KEY_MIN) begin
               ctrl.new_key = KEY_MIN;
            end else begin
               ctrl.new_key = head_key - KEY_W'(1);
            end
         end
         ACT_APPEND: begin
            ctrl.apply = fire && !full;
            if (empty) begin
               ctrl.new_key = START;
            end else if (tail_key == KEY_MAX) begin
               ctrl.new_key = KEY_MAX;
            end else begin
               ctrl.new_key = tail_key + KEY_W'(1);
            end
         end
         ACT_INSERT: begin
            ctrl.apply = fire && !full;
         end
         ACT_REMOVE_HEAD: begin
            ctrl.apply = fire && !empty;
         end
         ACT_REMOVE_KEY: begin
            ctrl.apply = fire && found;
         end
         default: begin
            ctrl.apply = 1'b0;
         end
      endcase
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic [PAYLOAD_W-1:0]    left_payload;
      logic                    left_before;
      logic signed [KEY_W-1:0] right_key;
      logic [PAYLOAD_W-1:0]    right_payload;

      if (i == 0) begin : g_head
         assign left_key     = ctrl.new_key;
         assign left_payload = ctrl.new_payload;
         assign left_before  = 1'b1;
      end else begin : g_body
         assign left_key     = cell_key[i-1];
         assign left_payload = cell_payload[i-1];
         assign left_before  = cell_flags[i-1].below;
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_key     = '0;
         assign right_payload = '0;
      end else begin : g_inner
         assign right_key     = cell_key[i+1];
         assign right_payload = cell_payload[i+1];
      end

      skl_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occupied      (occupied[i]),
         .append_slot   (append_slot[i]),
         .left_before   (left_before),
         .left_key      (left_key),
         .left_payload  (left_payload),
         .right_key     (right_key),
         .right_payload (right_payload),
         .flags         (cell_flags[i]),
         .key           (cell_key[i]),
         .payload       (cell_payload[i])
      );
   end

   // response and count update
   always_comb begin
      count_in       = count_ff;
      out_payload_in = '0;
      out_key_in     = '0;
      status_in      = STS_DONE;
      case (action)
         ACT_PREPEND, ACT_APPEND, ACT_INSERT: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_REMOVE_HEAD: begin
            if (empty) begin
               out_key_in = KEY_NONE;
               status_in  = STS_NOT_FOUND;
            end else begin
               out_key_in     = head_key;
               out_payload_in = cell_payload[0];
               count_in       = count_ff - CNT_W'(1);
            end
         end
         ACT_REMOVE_KEY: begin
            if (!found) begin
               out_key_in = KEY_NONE;
               status_in  = STS_NOT_FOUND;
            end else begin
               out_key_in     = req_sort_key;
               out_payload_in = match_payload;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_payload_ff <= out_payload_in;
         out_key_ff     <= out_key_in;
         status_ff      <= status_in;
      end
   end

   logic [COUNT_W-1:0] count_out_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         count_out_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_payload = out_payload_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_out_ff;

endmodule

/* tb/sv/skl_table_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skl_table_checker
// Keeps its own copy of the key-ordered table, works out the response of
// every accepted request and compares each accepted response, field by
// field, against the oldest outstanding one.
// ---------------------------------------------------------------------------
module skl_table_checker
   import skl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int          START_KEY   = START_KEY_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [ACTION_W-1:0]         req_action,
   input  logic [PAYLOAD_W-1:0]        req_payload,
   input  logic signed [KEY_W-1:0]     req_sort_key,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [PAYLOAD_W-1:0]        rsp_out_payload,
   input  logic signed [KEY_W-1:0]     rsp_out_key,
   input  logic [STATUS_W-1:0]         rsp_status,
   input  logic [COUNT_W-1:0]          rsp_entry_count,
   output int                          mismatches,
   output int                          outstanding
);

   typedef struct packed {
      logic [PAYLOAD_W-1:0]    payload;
      logic signed [KEY_W-1:0] key;
      logic [STATUS_W-1:0]     status;
      logic [COUNT_W-1:0]      count;
   } outcome_type;

   logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
   logic [PAYLOAD_W-1:0]    table_payloads [TABLE_DEPTH];
   int unsigned             table_fill;
   outcome_type             outcome_q [$];
   int                      fail_total;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      fail_total  = 0;
      table_fill  = 0;
   end

   function automatic outcome_type apply_request(
      input logic [ACTION_W-1:0]     act,
      input logic [PAYLOAD_W-1:0]    pay,
      input logic signed [KEY_W-1:0] skey
   );
      outcome_type             res;
      int unsigned             pos;
      int unsigned             i;
      logic signed [KEY_W-1:0] new_key;
      res        = '0;
      res.status = STS_DONE;
      case (act)
         ACT_PREPEND, ACT_APPEND, ACT_INSERT: begin
            if (table_fill >= TABLE_DEPTH) begin
               res.status = STS_FULL;
            end else begin
               if (act == ACT_PREPEND) begin
                  pos = 0;
                  if (table_fill == 0)
                     new_key = START_KEY;
                  else if (table_keys[0] == KEY_MIN)
                     new_key = KEY_MIN;
                  else
                     new_key = table_keys[0] - 1;
               end else if (act == ACT_APPEND) begin
                  pos = table_fill;
                  if (table_fill == 0)
                     new_key = START_KEY;
                  else if (table_keys[table_fill-1] == KEY_MAX)
                     new_key = KEY_MAX;
                  else
                     new_key = table_keys[table_fill-1] + 1;
               end else begin
                  pos = 0;
                  while (pos < table_fill && table_keys[pos] < skey)
                     pos++;
                  new_key = skey;
               end
               for (i = table_fill; i > pos; i--) begin
                  table_keys[i]     = table_keys[i-1];
                  table_payloads[i] = table_payloads[i-1];
               end
               table_keys[pos]     = new_key;
               table_payloads[pos] = pay;
               table_fill++;
            end
         end
         ACT_REMOVE_HEAD, ACT_REMOVE_KEY: begin
            pos = 0;
            if (act == ACT_REMOVE_KEY) begin
               while (pos < table_fill && table_keys[pos] != skey)
                  pos++;
            end
            if (pos >= table_fill) begin
               res.key    = KEY_NONE;
               res.status = STS_NOT_FOUND;
            end else begin
               res.key     = table_keys[pos];
               res.payload = table_payloads[pos];
               for (i = pos; i + 1 < table_fill; i++) begin
                  table_keys[i]     = table_keys[i+1];
                  table_payloads[i] = table_payloads[i+1];
               end
               table_fill--;
            end
         end
         default: begin
         end
      endcase
      res.count = COUNT_W'(table_fill);
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         outcome_q.delete();
         table_fill = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_payload, rsp_out_key, rsp_status, rsp_entry_count};
            if (outcome_q.size() == 0) begin
               if (fail_total < 10)
                  $display("unexpected response: payload %h key %0d status %0d count %0d",
                           got.payload, got.key, got.status, got.count);
               fail_total++;
            end else begin
               want = outcome_q.pop_front();
               if (got.payload !== want.payload || got.key !== want.key ||
                   got.status !== want.status || got.count !== want.count) begin
                  if (fail_total < 10)
                     $display("mismatch: expected payload %h key %0d status %0d count %0d, got payload %h key %0d status %0d count %0d",
                              want.payload, want.key, want.status, want.count,
                              got.payload, got.key, got.status, got.count);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            outcome_q.push_back(apply_request(req_action, req_payload, req_sort_key));
      end
      mismatches  <= fail_total;
      outstanding <= outcome_q.size();
   end

endmodule

/* tb/sv/tb_sorted_key_list_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_key_list_table
// Drives a short directed sequence (empty table, saturated derived keys,
// duplicate keys, reserved actions, full table) and then spells of mostly
// filling or mostly draining requests with random content, with random
// gaps on the request side and random stalls on the response side.
// ---------------------------------------------------------------------------
module tb_sorted_key_list_table
   import skl_pkg::*;
();

   localparam int                    RANDOM_ITEMS    = 1950;
   localparam int                    CYCLE_LIMIT     = 600000;
   localparam logic [ACTION_W-1:0]   ACT_RESERVED_LO = 3'd5;
   localparam logic [ACTION_W-1:0]   ACT_RESERVED_HI = 3'd7;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [ACTION_W-1:0]         req_action = '0;
   logic [PAYLOAD_W-1:0]        req_payload = '0;
   logic signed [KEY_W-1:0]     req_sort_key = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [PAYLOAD_W-1:0]        rsp_out_payload;
   logic signed [KEY_W-1:0]     rsp_out_key;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_entry_count;
   int                          mismatches;
   int                          outstanding;
   int                          cycle_count = 0;
   int                          sent_count = 0;
   int                          stall_left = 0;

   always #5 clock = ~clock;

   sorted_key_list_table u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_payload     (req_payload),
      .req_sort_key    (req_sort_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_key     (rsp_out_key),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   skl_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_payload     (req_payload),
      .req_sort_key    (req_sort_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_key     (rsp_out_key),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // response stalls, with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (((cycle_count / 256) % 4) != 1 && $urandom_range(0, 99) < 25)
            stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                       : $urandom_range(4, 30);
      end
   end

   task automatic send_request(
      input logic [ACTION_W-1:0]     act,
      input logic [PAYLOAD_W-1:0]    pay,
      input logic signed [KEY_W-1:0] skey
   );
      int unsigned gap;
      int unsigned roll;
      req_valid    <= 1'b1;
      req_action   <= act;
      req_payload  <= pay;
      req_sort_key <= skey;
      do
         @(posedge clock);
      while (req_stall);
      sent_count++;
      roll = $urandom_range(0, 99);
      if (((sent_count / 64) % 4) == 3 || roll < 65)
         gap = 0;
      else if (roll < 93)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(4, 20);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [ACTION_W-1:0]     act;
      logic [PAYLOAD_W-1:0]    pay;
      logic signed [KEY_W-1:0] skey;
      int unsigned             roll;
      bit                      filling;
      filling = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(ACT_REMOVE_HEAD, '0, '0);
      send_request(ACT_REMOVE_KEY, '0, START_KEY_DEF);
      send_request(ACT_PREPEND, 32'h1111_0001, '0);
      send_request(ACT_APPEND, 32'h2222_0002, '0);
      send_request(ACT_INSERT, '1, KEY_MIN);
      send_request(ACT_PREPEND, 32'h8000_0000, '0);
      send_request(ACT_INSERT, '0, KEY_MAX);
      send_request(ACT_APPEND, 32'h7FFF_FFFF, '0);
      send_request(ACT_INSERT, 32'h3333_0003, START_KEY_DEF);
      send_request(ACT_REMOVE_KEY, '0, START_KEY_DEF);
      send_request(ACT_REMOVE_KEY, '0, 32'h0BAD_0000);
      send_request(ACT_REMOVE_KEY, '0, KEY_MAX);
      for (int r = ACT_RESERVED_LO; r <= ACT_RESERVED_HI; r++)
         send_request(ACTION_W'(r), $urandom, $urandom);
      // fill past capacity; the last three, one of each kind, are dropped
      for (int k = 0; k < 14; k++) begin
         if (k % 3 == 0)
            act = ACT_PREPEND;
         else if (k % 3 == 1)
            act = ACT_APPEND;
         else
            act = ACT_INSERT;
         send_request(act, $urandom, $urandom);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 48 == 0)
            filling = ~filling;
         roll = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 22)      act = ACT_PREPEND;
            else if (roll < 44) act = ACT_APPEND;
            else if (roll < 76) act = ACT_INSERT;
            else if (roll < 86) act = ACT_REMOVE_HEAD;
            else if (roll < 97) act = ACT_REMOVE_KEY;
            else                act = ACTION_W'($urandom_range(ACT_RESERVED_LO,
                                                               ACT_RESERVED_HI));
         end else begin
            if (roll < 6)       act = ACT_PREPEND;
            else if (roll < 12) act = ACT_APPEND;
            else if (roll < 30) act = ACT_INSERT;
            else if (roll < 62) act = ACT_REMOVE_HEAD;
            else if (roll < 97) act = ACT_REMOVE_KEY;
            else                act = ACTION_W'($urandom_range(ACT_RESERVED_LO,
                                                               ACT_RESERVED_HI));
         end
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            skey = START_KEY_DEF - 8 + $urandom_range(0, 16);
         end else if (roll < 72) begin
            case ($urandom_range(0, 5))
               0:       skey = KEY_MIN;
               1:       skey = KEY_MAX;
               2:       skey = KEY_MIN + 1;
               3:       skey = KEY_MAX - 1;
               4:       skey = KEY_NONE;
               default: skey = '0;
            endcase
         end else begin
            skey = $urandom;
         end
         roll = $urandom_range(0, 99);
         if (roll < 5)       pay = '0;
         else if (roll < 10) pay = '1;
         else                pay = $urandom;
         send_request(act, pay, skey);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
